### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the prescaler/reload search block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/tprs_pkg.sv
// Package for the timer prescaler/reload search block: widths, register
// codes, limits and the structs between its modules. No dependencies.
`timescale 1ns / 1ps

package tprs_pkg;

   localparam int HZ_W         = 28;
   localparam int DIV_W        = 5;
   localparam int PSC_W        = 16;
   localparam int RLD_W        = 16;
   localparam int DEN_W        = PSC_W + 1 + HZ_W;
   localparam int DCNT_W       = $clog2(HZ_W);
   localparam int COUNTER_BITS = 16;
   localparam int ADDR_W       = 4;

   localparam logic [32:0]       CNT_MAX       = 33'((64'd1 << COUNTER_BITS) - 64'd1);
   localparam logic [PSC_W-1:0]  PSC_LAST      = '1;
   localparam logic [HZ_W-1:0]   SYS_CLK_RESET = 28'd80000000;
   localparam logic [DIV_W-1:0]  SLOW_RESET    = 5'd2;
   localparam logic [DIV_W-1:0]  FAST_RESET    = 5'd1;

   localparam logic [1:0] REG_SYS_CLK  = 2'd0;
   localparam logic [1:0] REG_SLOW_DIV = 2'd1;
   localparam logic [1:0] REG_FAST_DIV = 2'd2;

   typedef struct packed {
      logic [HZ_W-1:0]  sys_clk;
      logic [DIV_W-1:0] slow_div;
      logic [DIV_W-1:0] fast_div;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [HZ_W-1:0]  dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [HZ_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/core/tprs_csr.sv
// Configuration registers of the prescaler/reload search, APB-style access.
// Depends on tprs_pkg.
`timescale 1ns / 1ps

module tprs_csr import tprs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_SYS_CLK:  cfg_in.sys_clk  = csr_pwdata[HZ_W-1:0];
            REG_SLOW_DIV: cfg_in.slow_div = csr_pwdata[DIV_W-1:0];
            REG_FAST_DIV: cfg_in.fast_div = csr_pwdata[DIV_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SYS_CLK:  csr_prdata = 32'(cfg_ff.sys_clk);
         REG_SLOW_DIV: csr_prdata = 32'(cfg_ff.slow_div);
         REG_FAST_DIV: csr_prdata = 32'(cfg_ff.fast_div);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sys_clk  <= SYS_CLK_RESET;
         cfg_ff.slow_div <= SLOW_RESET;
         cfg_ff.fast_div <= FAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/tprs_div.sv
// Shared restoring divider, one quotient bit per cycle, done pulse at the end.
// Depends on tprs_pkg.
`timescale 1ns / 1ps

module tprs_div import tprs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [HZ_W-1:0]   q_ff, q_in;
   logic [HZ_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]  dsr_ff, dsr_in;
   logic [HZ_W:0]     trial;
   logic              ge;

   assign trial = {rem_ff, q_ff[HZ_W-1]};
   assign ge    = DEN_W'(trial) >= dsr_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == '0);
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(HZ_W - 1);
         q_in    = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? HZ_W'(DEN_W'(trial) - dsr_ff) : trial[HZ_W-1:0];
         q_in   = {q_ff[HZ_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

### rtl/core/timer_prescaler_reload_search.sv
// Top level of the timer prescaler/reload search: sequencer over the shared
// divider, result register. Depends on tprs_pkg, tprs_csr, tprs_div, assert_macros.svh.
//
//   channel | direction | content
//   req_*   | in        | tdata[27:0] target_hz, tuser[0] on_fast_bus
//   rsp_*   | out       | tdata[15:0] prescaler, [31:16] reload, tuser[0] no_match
//   csr_*   | in/out    | APB: 0x0 system_clock_hz, 0x4 slow_bus_divider, 0x8 fast_bus_divider
//
// One item at a time: one division for the bus clock, then for each prescaler tried
// one or two divisions on the shared divider plus steps. A zero target skips the
// divisions and goes straight to the result state.
// Synchronous active-high reset clears the sequencer and result valid.
// A stalled result holds in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module timer_prescaler_reload_search import tprs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [27:0] target_hz, [31:28] zero
   input  logic              req_tuser,   // [0] on_fast_bus
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [15:0] prescaler, [31:16] reload
   output logic              rsp_tuser,   // [0] no_match
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLK_DIV, S_CLK_WAIT, S_MUL1, S_DIV1, S_WAIT1, S_CHECK,
      S_MUL2, S_DIV2, S_WAIT2, S_CMP, S_DONE
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type        state_ff, state_in;
   logic [HZ_W-1:0]  f_ff, f_in;
   logic [HZ_W-1:0]  clk_ff, clk_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [PSC_W-1:0] p_ff, p_in;
   logic [HZ_W-1:0]  ideal_ff, ideal_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [HZ_W-1:0]  min_err_ff, min_err_in;
   logic [PSC_W-1:0] best_p_ff, best_p_in;
   logic [RLD_W-1:0] best_a_ff, best_a_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   logic             req_xfer;
   logic [DIV_W-1:0] div_sel;
   logic [PSC_W:0]   p_one;
   logic [HZ_W-1:0]  mul_b;
   logic [DEN_W-1:0] product;
   logic [HZ_W-1:0]  a_val;
   logic [HZ_W-1:0]  err;
   logic             div_wait;

   tprs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tprs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign div_sel = req_tuser ? cfg.fast_div : cfg.slow_div;
   assign p_one   = {1'b0, p_ff} + 1'b1;
   assign mul_b   = (state_ff == S_MUL1) ? f_ff : ideal_ff;
   assign product = DEN_W'(p_one) * DEN_W'(mul_b);
   assign a_val   = ideal_ff - 1'b1;
   assign err     = (div_rsp.quotient > f_ff) ? div_rsp.quotient - f_ff
                                              : f_ff - div_rsp.quotient;

   assign div_wait = (state_ff == S_CLK_WAIT) || (state_ff == S_WAIT1) ||
                     (state_ff == S_WAIT2);

   assign div_req.start    = (state_ff == S_CLK_DIV) || (state_ff == S_DIV1) ||
                             (state_ff == S_DIV2);
   assign div_req.dividend = (state_ff == S_CLK_DIV) ? cfg.sys_clk : clk_ff;
   assign div_req.divisor  = den_ff;

   always_comb begin
      state_in     = state_ff;
      f_in         = f_ff;
      clk_in       = clk_ff;
      div_in       = div_ff;
      p_in         = p_ff;
      ideal_in     = ideal_ff;
      den_in       = den_ff;
      min_err_in   = min_err_ff;
      best_p_in    = best_p_ff;
      best_a_in    = best_a_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               f_in        = req_tdata[HZ_W-1:0];
               div_in      = (div_sel == '0) ? DIV_W'(1) : div_sel;
               den_in      = DEN_W'((div_sel == '0) ? DIV_W'(1) : div_sel);
               p_in        = '0;
               min_err_in  = req_tdata[HZ_W-1:0];
               best_p_in   = '0;
               best_a_in   = '0;
               found_in    = 1'b0;
               state_in    = (req_tdata[HZ_W-1:0] == '0) ? S_DONE : S_CLK_DIV;
            end
         end
         S_CLK_DIV: state_in = S_CLK_WAIT;
         S_CLK_WAIT: begin
            if (div_rsp.done) begin
               clk_in   = (div_ff > DIV_W'(1)) ? {div_rsp.quotient[HZ_W-2:0], 1'b0}
                                                : div_rsp.quotient;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            den_in   = product;
            state_in = S_DIV1;
         end
         S_DIV1: state_in = S_WAIT1;
         S_WAIT1: begin
            if (div_rsp.done) begin
               ideal_in = div_rsp.quotient;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ideal_ff == '0) begin
               state_in = S_DONE;
            end else if (33'(a_val) > CNT_MAX) begin
               if (p_ff == PSC_LAST) begin
                  state_in = S_DONE;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = S_MUL1;
               end
            end else begin
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            den_in   = product;
            state_in = S_DIV2;
         end
         S_DIV2: state_in = S_WAIT2;
         S_WAIT2: begin
            if (div_rsp.done) begin
               state_in = S_CMP;
               if (err < min_err_ff) begin
                  min_err_in  = err;
                  best_p_in   = p_ff;
                  best_a_in   = a_val[RLD_W-1:0];
                  found_in    = 1'b1;
               end
            end
         end
         S_CMP: begin
            if ((min_err_ff == '0 && found_ff) || p_ff == PSC_LAST) begin
               state_in = S_DONE;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = S_MUL1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {best_a_ff, best_p_ff};
               rsp_user_in  = !found_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      f_ff        <= f_in;
      clk_ff      <= clk_in;
      div_ff      <= div_in;
      p_ff        <= p_in;
      ideal_ff    <= ideal_in;
      den_ff      <= den_in;
      min_err_ff  <= min_err_in;
      best_p_ff   <= best_p_in;
      best_a_ff   <= best_a_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, !req_tready)
   `ASSERT_IMPLIES(a_nomatch_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, div_rsp.done, div_wait)

endmodule

### tb/sv/testbench.sv
// Self-checking bench for timer_prescaler_reload_search: streams target frequencies
// through the request channel, predicts each prescaler/reload pair and checks the results.
// Depends on tprs_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
   import tprs_pkg::*;

   localparam int          HOLD_CYCLES    = 500;
   localparam int          TAIL_CYCLES    = 100;
   localparam int unsigned RAND_TRIES     = 128;
   localparam int unsigned ALL_TRIES      = 65536;
   localparam int          WATCHDOG_LIMIT = 600000;

   typedef struct packed {
      logic [PSC_W-1:0] prescaler;
      logic [RLD_W-1:0] reload;
      logic             no_match;
   } timer_pair_type;

   typedef struct {
      logic            on_fast;
      logic [HZ_W-1:0] target_hz;
      int              gap;
      bit              drain;
   } target_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic [HZ_W-1:0]  sys_hz   = SYS_CLK_RESET;
   logic [DIV_W-1:0] slow_div = SLOW_RESET;
   logic [DIV_W-1:0] fast_div = FAST_RESET;

   target_item_type target_q[$];
   timer_pair_type  pair_q[$];
   target_item_type nxt;
   bit           staged = 0;
   bit           offer_next;
   int           gap_left = 0;
   bit           req_took = 0;
   bit           rsp_took = 0;
   bit           csr_took = 0;
   bit           tx_calm = 0;
   bit           rx_calm = 0;
   bit           hold_armed = 0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           idle_cycles = 0;
   int           errors = 0;

   timer_prescaler_reload_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] bus_clock(input logic on_fast);
      logic [63:0] div;
      logic [63:0] clk;
      div = on_fast ? 64'(fast_div) : 64'(slow_div);
      if (div == 0) div = 1;
      clk = 64'(sys_hz) / div;
      if (div > 1) clk = clk * 2;
      return clk;
   endfunction

   function automatic timer_pair_type search_pair(input logic on_fast,
                                                  input logic [HZ_W-1:0] target,
                                                  input int unsigned try_cap,
                                                  output int unsigned tries);
      logic [63:0] clk;
      logic [63:0] cmax;
      logic [63:0] p;
      logic [63:0] ideal;
      logic [63:0] rl;
      logic [63:0] actual;
      logic [63:0] err;
      logic [63:0] min_err;
      timer_pair_type best;
      best.prescaler = '0;
      best.reload    = '0;
      best.no_match  = 1'b1;
      tries    = 0;
      clk      = bus_clock(on_fast);
      cmax     = (64'd1 << COUNTER_BITS) - 64'd1;
      min_err  = 64'(target);
      if (target != 0) begin
         for (p = 0; p <= 64'(PSC_LAST) && tries < try_cap; p++) begin
            tries++;
            ideal = clk / ((p + 1) * 64'(target));
            if (ideal == 0) break;
            rl = ideal - 1;
            if (rl > cmax) continue;
            actual = clk / ((p + 1) * ideal);
            err = (actual > 64'(target)) ? actual - 64'(target) : 64'(target) - actual;
            if (err < min_err) begin
               min_err        = err;
               best.prescaler = p[PSC_W-1:0];
               best.reload    = rl[RLD_W-1:0];
               best.no_match  = 1'b0;
               if (err == 0) break;
            end
         end
      end
      return best;
   endfunction

   // redraw until the search stays short
   function automatic logic [HZ_W-1:0] pick_target(input logic on_fast);
      logic [63:0] clk;
      logic [63:0] f;
      int unsigned tries;
      clk = bus_clock(on_fast);
      do begin
         case ($urandom_range(0, 9))
            0:          f = 0;
            1, 2:       f = $urandom_range(0, (1 << HZ_W) - 1);
            3, 4, 5, 6: f = clk / $urandom_range(1, 64) + $urandom_range(0, 7);
            7, 8:       f = clk / $urandom_range(1, 1 << 22);
            default:    f = $urandom_range(1, 1 << 16);
         endcase
         if (f >= (64'd1 << HZ_W)) f = (64'd1 << HZ_W) - 1;
         void'(search_pair(on_fast, f[HZ_W-1:0], RAND_TRIES + 1, tries));
      end while (tries > RAND_TRIES);
      return f[HZ_W-1:0];
   endfunction

   function automatic void check_field(input string name, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         errors++;
      end
   endfunction

   // sample transfers, predict and check
   always @(posedge clock) begin
      timer_pair_type want;
      timer_pair_type got;
      int unsigned tries;
      req_took = !reset && req_tvalid && req_tready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      csr_took = csr_psel && csr_penable && csr_pready;
      if (req_took)
         pair_q.push_back(search_pair(req_tuser, req_tdata[HZ_W-1:0], ALL_TRIES, tries));
      if (rsp_took) begin
         got.prescaler = rsp_tdata[15:0];
         got.reload    = rsp_tdata[31:16];
         got.no_match  = rsp_tuser;
         if (pair_q.size() == 0) begin
            $error("result transfer with nothing expected: %s %0d reload %0d no_match %0d",
                   "prescaler", got.prescaler, got.reload, got.no_match);
            errors++;
         end else begin
            want = pair_q.pop_front();
            check_field("prescaler", 32'(want.prescaler), 32'(got.prescaler));
            check_field("reload", 32'(want.reload), 32'(got.reload));
            check_field("no_match", 32'(want.no_match), 32'(got.no_match));
         end
      end
      if (req_took || rsp_took || csr_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL timer_prescaler_reload_search");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      offer_next = 0;
      if (!reset) begin
         if (req_tvalid && !req_took) begin
            offer_next = 1;
         end else begin
            if (!staged && target_q.size() != 0) begin
               nxt      = target_q.pop_front();
               staged   = 1;
               gap_left = nxt.gap;
            end
            if (staged) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!nxt.drain || pair_q.size() == 0) begin
                  offer_next = 1;
                  staged     = 0;
                  req_tdata  <= 32'(nxt.target_hz);
                  req_tuser  <= nxt.on_fast;
               end
            end
         end
      end
      req_tvalid <= offer_next;
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_armed) begin
            hold_armed = 0;
            hold_left  = HOLD_CYCLES;
         end
         if (rsp_took) stall_left = rx_calm ? 0 : $urandom_range(0, 19);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SYS_CLK:  begin sys_hz = value[HZ_W-1:0];    readback = 32'(sys_hz);   end
         REG_SLOW_DIV: begin slow_div = value[DIV_W-1:0]; readback = 32'(slow_div); end
         default:      begin fast_div = value[DIV_W-1:0]; readback = 32'(fast_div); end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr readback", readback, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_target(input logic on_fast, input logic [HZ_W-1:0] target, input int gap,
                               input bit drain);
      target_item_type it;
      it.on_fast   = on_fast;
      it.target_hz = target;
      it.gap       = gap;
      it.drain     = drain;
      target_q.push_back(it);
   endtask

   task automatic wait_idle();
      while (target_q.size() != 0 || staged || req_tvalid || pair_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] sys, input logic [31:0] slow,
                            input logic [31:0] fast, input int count, input bit quiet_tx,
                            input bit quiet_rx, input bit long_hold, input int drain_at);
      logic f_sel;
      csr_write(REG_SYS_CLK, sys);
      csr_write(REG_SLOW_DIV, slow);
      csr_write(REG_FAST_DIV, fast);
      tx_calm    = quiet_tx;
      rx_calm    = quiet_rx;
      hold_armed = long_hold;
      for (int i = 0; i < count; i++) begin
         f_sel = $urandom_range(0, 1);
         queue_target(f_sel, pick_target(f_sel), tx_calm ? 0 : $urandom_range(0, 19),
                      i == drain_at);
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: both buses run the timer at 80 MHz
      queue_target(1'b0, 28'd0, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd0, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd1000000, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'd2000000, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'hFFFFFFF, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd200000000, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'd80000000, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd80000001, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'd40000001, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd3000000, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'hAAAAAAA, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'h5555555, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'd1000, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd1220, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'd1221, $urandom_range(0, 19), 0);
      queue_target(1'b1, 28'd1, $urandom_range(0, 19), 0);
      queue_target(1'b0, 28'h8000000, $urandom_range(0, 19), 0);
      wait_idle();

      run_phase(200000000, 16, 1, 18, 0, 0, 0, -1);
      run_phase(1, 0, 31, 12, 0, 0, 0, -1);
      run_phase(0, 1, 16, 12, 1, 0, 1, -1);
      run_phase(32'hFFFFFFF, 3, 2, 18, 1, 1, 0, -1);
      run_phase($urandom_range(1, 200000000), $urandom_range(1, 16), $urandom_range(1, 16),
                18, 0, 0, 0, -1);
      run_phase(80000000, 2, 1, 22, 0, 0, 0, 10);

      if (errors == 0 && pair_q.size() == 0)
         $display("PASS timer_prescaler_reload_search");
      else
         $display("FAIL timer_prescaler_reload_search");
      $finish;
   end

endmodule
